// ===== design/qnn_pkg.sv =====
// ----------------------------------------------------------------------------
// qnn_pkg
// Shared constants and the front-to-back item type of the quad normal unit.
// ----------------------------------------------------------------------------
package qnn_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // magnitudes handed to the back end are below 2^31
    localparam int MAG_BITS  = 31;
    // sum of three squares of MAG_BITS values
    localparam int SUM_BITS  = 64;
    localparam int LANES     = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                           degen;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][MAG_BITS-1:0] mag;
    } mid_item_t;

endpackage

// ===== design/qnn_fifo.sv =====
// ----------------------------------------------------------------------------
// qnn_fifo
// Small register queue with push/full and pop/empty; head shown while not empty.
// ----------------------------------------------------------------------------
module qnn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             wr_go, rd_go;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_go = push && !full;
    assign rd_go = pop && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_go)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_go)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_go && !rd_go)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_go && !wr_go)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("queue count over depth");
    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_go && !rd_go) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on transfer in");
    a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_go && !wr_go) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on transfer out");
`endif

endmodule

// ===== design/qnn_front.sv =====
// ----------------------------------------------------------------------------
// qnn_front
// Diagonals, cross product, sign/magnitude split, degenerate flag and the
// staged right shift that brings the largest magnitude below 2^31.
// ----------------------------------------------------------------------------
module qnn_front #(
    parameter int COORD_BITS = qnn_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_push,
    output logic                         in_full,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    input  logic signed [COORD_BITS-1:0] d_x,
    input  logic signed [COORD_BITS-1:0] d_y,
    input  logic signed [COORD_BITS-1:0] d_z,
    output logic                         out_push,
    input  logic                         out_full,
    output qnn_pkg::mid_item_t           out_item
);
    import qnn_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int PRE   = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int PW    = DW - PRE;
    localparam int PPW   = 2 * PW;
    localparam int NW    = PPW + 1;
    localparam int MW    = PPW;
    localparam int MAXSH = (MW > MAG_BITS) ? MW - MAG_BITS : 0;
    localparam int SHB   = $clog2(MAXSH + 1);
    localparam int FS    = 4 + SHB;

    logic [FS-1:0] vld_reg, vld_next;
    logic          adv;
    logic          take;

    assign adv      = !vld_reg[FS-1] || !out_full;
    assign in_full  = !adv;
    assign take     = in_push && adv;
    assign out_push = vld_reg[FS-1] && !out_full;
    assign vld_next = {vld_reg[FS-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // diagonals: p = C - A in 0..2, q = D - B in 3..5
    logic [COORD_BITS-1:0] hi_w [6];
    logic [COORD_BITS-1:0] lo_w [6];
    logic [DW-1:0]         diff_w [6];
    logic [DW-1:0]         dmag_w [6];
    logic [DW-1:0]         dsh_w  [6];
    logic [PW-1:0]         dcut_w [6];
    logic [PW-1:0]         diag_next [6];
    logic [PW-1:0]         diag_reg  [6];

    assign hi_w[0] = c_x;
    assign hi_w[1] = c_y;
    assign hi_w[2] = c_z;
    assign hi_w[3] = d_x;
    assign hi_w[4] = d_y;
    assign hi_w[5] = d_z;
    assign lo_w[0] = a_x;
    assign lo_w[1] = a_y;
    assign lo_w[2] = a_z;
    assign lo_w[3] = b_x;
    assign lo_w[4] = b_y;
    assign lo_w[5] = b_z;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            diff_w[k] = {hi_w[k][COORD_BITS-1], hi_w[k]} - {lo_w[k][COORD_BITS-1], lo_w[k]};
            dmag_w[k] = diff_w[k][DW-1] ? (~diff_w[k] + 1'b1) : diff_w[k];
            // magnitude truncated toward zero for wide coordinates
            dsh_w[k]  = dmag_w[k] >> PRE;
            dcut_w[k] = dsh_w[k][PW-1:0];
            diag_next[k] = diff_w[k][DW-1] ? (~dcut_w[k] + 1'b1) : dcut_w[k];
        end
    end

    // products: yz, zy, zx, xz, xy, yx
    logic [PPW-1:0] prod_next [6];
    logic [PPW-1:0] prod_reg  [6];

    assign prod_next[0] = $signed(diag_reg[1]) * $signed(diag_reg[5]);
    assign prod_next[1] = $signed(diag_reg[2]) * $signed(diag_reg[4]);
    assign prod_next[2] = $signed(diag_reg[2]) * $signed(diag_reg[3]);
    assign prod_next[3] = $signed(diag_reg[0]) * $signed(diag_reg[5]);
    assign prod_next[4] = $signed(diag_reg[0]) * $signed(diag_reg[4]);
    assign prod_next[5] = $signed(diag_reg[1]) * $signed(diag_reg[3]);

    logic [NW-1:0] cross_next [LANES];
    logic [NW-1:0] cross_reg  [LANES];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            cross_next[k] = {prod_reg[2*k][PPW-1], prod_reg[2*k]}
                          - {prod_reg[2*k+1][PPW-1], prod_reg[2*k+1]};
        end
    end

    // magnitude stage (index 0) followed by SHB shift stages
    logic [MW-1:0]    mag_reg   [SHB+1][LANES];
    logic [MW-1:0]    mag_next  [SHB+1][LANES];
    logic [LANES-1:0] neg_reg   [SHB+1];
    logic [LANES-1:0] neg_next  [SHB+1];
    logic             degen_reg [SHB+1];
    logic             degen_next[SHB+1];
    logic [NW-1:0]    nmag_w [LANES];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            nmag_w[k]      = cross_reg[k][NW-1] ? (~cross_reg[k] + 1'b1) : cross_reg[k];
            mag_next[0][k] = nmag_w[k][MW-1:0];
            neg_next[0][k] = cross_reg[k][NW-1];
        end
        degen_next[0] = (cross_reg[0] == '0) && (cross_reg[1] == '0) && (cross_reg[2] == '0);
    end

    for (genvar i = 1; i <= SHB; i++)
    begin : g_shift
        localparam int AMT = 1 << (SHB - i);
        logic big;

        // shift by AMT when the largest magnitude needs at least AMT more
        always_comb
        begin
            big = 1'b0;
            for (int k = 0; k < LANES; k++)
            begin
                big = big || ((mag_reg[i-1][k] >> (MAG_BITS - 1 + AMT)) != '0);
            end
            for (int k = 0; k < LANES; k++)
            begin
                mag_next[i][k] = big ? (mag_reg[i-1][k] >> AMT) : mag_reg[i-1][k];
            end
            neg_next[i]   = neg_reg[i-1];
            degen_next[i] = degen_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diag_reg  <= diag_next;
            prod_reg  <= prod_next;
            cross_reg <= cross_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            degen_reg <= degen_next;
        end
    end

    assign out_item.degen = degen_reg[SHB];
    assign out_item.neg   = neg_reg[SHB];

    for (genvar k = 0; k < LANES; k++)
    begin : g_out
        if (MW >= MAG_BITS)
        begin : g_cut
            assign out_item.mag[k] = mag_reg[SHB][k][MAG_BITS-1:0];
        end
        else
        begin : g_ext
            assign out_item.mag[k] = MAG_BITS'(mag_reg[SHB][k]);
        end
    end

endmodule

// ===== design/qnn_back.sv =====
// ----------------------------------------------------------------------------
// qnn_back
// Sum of squares, then per lane a radix-2 divider for 4*v^2*2^(2F)/S and a
// digit-serial square root pipeline; round and apply the sign.
// ----------------------------------------------------------------------------
module qnn_back #(
    parameter int NORMAL_FRAC_BITS = qnn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_empty,
    output logic                           in_pop,
    input  qnn_pkg::mid_item_t             in_item,
    output logic                           out_push,
    input  logic                           out_full,
    output logic [3*NORMAL_FRAC_BITS+6:0]  out_data
);
    import qnn_pkg::*;

    localparam int F   = NORMAL_FRAC_BITS;
    localparam int QW  = 2 * F + 3;
    localparam int QE  = 2 * F + 4;
    localparam int RB  = F + 2;
    localparam int OW  = F + 2;
    localparam int SQW = 2 * MAG_BITS;
    localparam int SW  = SUM_BITS;
    localparam int BS  = 2 + QW + RB + 1;

    logic [BS-1:0] vld_reg, vld_next;
    logic          adv;
    logic          take;

    assign adv      = !vld_reg[BS-1] || !out_full;
    assign take     = !in_empty && adv;
    assign in_pop   = take;
    assign out_push = vld_reg[BS-1] && !out_full;
    assign vld_next = {vld_reg[BS-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // squares
    logic [SQW-1:0]   sq_reg [LANES];
    logic [SQW-1:0]   sq_next[LANES];
    logic [LANES-1:0] sq_neg_reg;
    logic             sq_degen_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sq_next[k] = in_item.mag[k] * in_item.mag[k];
        end
    end

    // sum
    logic [SW-1:0]    s_next, s_reg;
    logic [SW-1:0]    v2_reg [LANES];
    logic [LANES-1:0] sum_neg_reg;
    logic             sum_degen_reg;

    assign s_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg        <= sq_next;
            sq_neg_reg    <= in_item.neg;
            sq_degen_reg  <= in_item.degen;
            s_reg         <= s_next;
            for (int k = 0; k < LANES; k++)
            begin
                v2_reg[k] <= SW'(sq_reg[k]);
            end
            sum_neg_reg   <= sq_neg_reg;
            sum_degen_reg <= sq_degen_reg;
        end
    end

    // divider: one quotient bit per stage
    logic [SW-1:0]    dr_reg  [QW][LANES];
    logic [SW-1:0]    dr_next [QW][LANES];
    logic [QW-1:0]    dq_reg  [QW][LANES];
    logic [QW-1:0]    dq_next [QW][LANES];
    logic [SW-1:0]    ds_reg  [QW];
    logic [LANES-1:0] dneg_reg[QW];
    logic             ddeg_reg[QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [SW:0] t_w [LANES];
        logic [SW:0] d_w [LANES];
        logic        ge_w[LANES];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    t_w[k]        = {1'b0, v2_reg[k]};
                    d_w[k]        = t_w[k] - {1'b0, s_reg};
                    ge_w[k]       = !d_w[k][SW];
                    dr_next[j][k] = ge_w[k] ? d_w[k][SW-1:0] : t_w[k][SW-1:0];
                    dq_next[j][k] = QW'(ge_w[k]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ds_reg[j]   <= s_reg;
                    dneg_reg[j] <= sum_neg_reg;
                    ddeg_reg[j] <= sum_degen_reg;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    t_w[k]        = {dr_reg[j-1][k], 1'b0};
                    d_w[k]        = t_w[k] - {1'b0, ds_reg[j-1]};
                    ge_w[k]       = t_w[k] >= {1'b0, ds_reg[j-1]};
                    dr_next[j][k] = ge_w[k] ? d_w[k][SW-1:0] : t_w[k][SW-1:0];
                    dq_next[j][k] = {dq_reg[j-1][k][QW-2:0], ge_w[k]};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ds_reg[j]   <= ds_reg[j-1];
                    dneg_reg[j] <= dneg_reg[j-1];
                    ddeg_reg[j] <= ddeg_reg[j-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[j] <= dr_next[j];
                dq_reg[j] <= dq_next[j];
            end
        end
    end

    // square root: one root bit per stage
    logic [RB:0]      rr_reg   [RB][LANES];
    logic [RB:0]      rr_next  [RB][LANES];
    logic [RB-1:0]    rt_reg   [RB][LANES];
    logic [RB-1:0]    rt_next  [RB][LANES];
    logic [QE-1:0]    rq_reg   [RB][LANES];
    logic [QE-1:0]    rq_next  [RB][LANES];
    logic [LANES-1:0] rneg_reg [RB];
    logic             rdeg_reg [RB];

    for (genvar j = 0; j < RB; j++)
    begin : g_sqrt
        logic [RB:0]   rem_w [LANES];
        logic [RB-1:0] root_w[LANES];
        logic [QE-1:0] qv_w  [LANES];
        logic [RB+2:0] t_w   [LANES];
        logic [RB+2:0] tr_w  [LANES];
        logic [RB+2:0] d_w   [LANES];
        logic          ge_w  [LANES];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    rem_w[k]  = '0;
                    root_w[k] = '0;
                    qv_w[k]   = QE'(dq_reg[QW-1][k]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rneg_reg[j] <= dneg_reg[QW-1];
                    rdeg_reg[j] <= ddeg_reg[QW-1];
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    rem_w[k]  = rr_reg[j-1][k];
                    root_w[k] = rt_reg[j-1][k];
                    qv_w[k]   = rq_reg[j-1][k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rneg_reg[j] <= rneg_reg[j-1];
                    rdeg_reg[j] <= rdeg_reg[j-1];
                end
            end
        end

        always_comb
        begin
            for (int k = 0; k < LANES; k++)
            begin
                t_w[k]  = {rem_w[k], qv_w[k][QE-1:QE-2]};
                tr_w[k] = {1'b0, root_w[k], 2'b01};
                d_w[k]  = t_w[k] - tr_w[k];
                ge_w[k] = t_w[k] >= tr_w[k];
                rr_next[j][k] = ge_w[k] ? d_w[k][RB:0] : t_w[k][RB:0];
                rt_next[j][k] = {root_w[k][RB-2:0], ge_w[k]};
                rq_next[j][k] = {qv_w[k][QE-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rr_reg[j] <= rr_next[j];
                rt_reg[j] <= rt_next[j];
                rq_reg[j] <= rq_next[j];
            end
        end
    end

    // round: n = (root + 1) / 2, then sign
    logic [RB:0]   rnd_w [LANES];
    logic [OW-1:0] mag_w [LANES];
    logic [OW-1:0] res_next[LANES];
    logic [OW-1:0] res_reg [LANES];
    logic          deg_out_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rnd_w[k]    = {1'b0, rt_reg[RB-1][k]} + 1'b1;
            mag_w[k]    = rnd_w[k][RB:1];
            res_next[k] = rdeg_reg[RB-1] ? '0
                        : (rneg_reg[RB-1][k] ? (~mag_w[k] + 1'b1) : mag_w[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg     <= res_next;
            deg_out_reg <= rdeg_reg[RB-1];
        end
    end

    assign out_data = {deg_out_reg, res_reg[2], res_reg[1], res_reg[0]};

endmodule

// ===== design/quad_newell_normal.sv =====
// Throughput: one quad per cycle while no stage is held by a full queue; every
//   stage is a fixed pipeline step.
// Reset: rst_n clears the queues and all stage valid bits; data registers keep garbage.
// ----------------------------------------------------------------------------
// quad_newell_normal
// Unit normal of a quad by Newell's method (diagonal cross product), scaled to
// Q1.14 with round-to-nearest, and a flag for a zero sum.
// ----------------------------------------------------------------------------
//
// Structure:
//   front  - accepts corners, forms diagonals and cross product, classifies a
//            zero vector, and pre-shifts large magnitudes below 2^31.
//   queue  - short register queue so the front and back stall independently.
//   back   - squares and their sum, then per component a restoring divider
//            for 4*v^2*2^(2F)/S and an integer square root. The rounded value
//            is floor((isqrt(Q) + 1) / 2), which equals the nearest integer
//            to |v|*2^F/sqrt(S) with ties going up.
//   output - result queue; the head is on the ports while empty is low.
// A degenerate quad travels the same path and comes out as a zero vector.
//
module quad_newell_normal #(
    parameter int COORD_BITS       = qnn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = qnn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [COORD_BITS-1:0]       a_x,
    input  logic signed [COORD_BITS-1:0]       a_y,
    input  logic signed [COORD_BITS-1:0]       a_z,
    input  logic signed [COORD_BITS-1:0]       b_x,
    input  logic signed [COORD_BITS-1:0]       b_y,
    input  logic signed [COORD_BITS-1:0]       b_z,
    input  logic signed [COORD_BITS-1:0]       c_x,
    input  logic signed [COORD_BITS-1:0]       c_y,
    input  logic signed [COORD_BITS-1:0]       c_z,
    input  logic signed [COORD_BITS-1:0]       d_x,
    input  logic signed [COORD_BITS-1:0]       d_y,
    input  logic signed [COORD_BITS-1:0]       d_z,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
    output logic                               degenerate
);
    import qnn_pkg::*;

    localparam int OW    = NORMAL_FRAC_BITS + 2;
    localparam int OUT_W = 3 * OW + 1;
    localparam int MID_W = $bits(mid_item_t);

    localparam logic signed [OW-1:0] NMAX = OW'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [OW-1:0] NMIN = -NMAX;

    // front to middle queue
    logic       mid_push, mid_full, mid_pop, mid_empty;
    mid_item_t  mid_in, mid_out;
    logic [MID_W-1:0] mid_dout;

    // back to result queue
    logic             res_push, res_full;
    logic [OUT_W-1:0] res_din, res_dout;

    qnn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (push),
        .in_full  (full),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_z      (a_z),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_z      (b_z),
        .c_x      (c_x),
        .c_y      (c_y),
        .c_z      (c_z),
        .d_x      (d_x),
        .d_y      (d_y),
        .d_z      (d_z),
        .out_push (mid_push),
        .out_full (mid_full),
        .out_item (mid_in)
    );

    qnn_fifo #(
        .WIDTH (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .din   (mid_in),
        .pop   (mid_pop),
        .empty (mid_empty),
        .dout  (mid_dout)
    );

    assign mid_out = mid_item_t'(mid_dout);

    qnn_back #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (mid_empty),
        .in_pop   (mid_pop),
        .in_item  (mid_out),
        .out_push (res_push),
        .out_full (res_full),
        .out_data (res_din)
    );

    qnn_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_din),
        .pop   (pop),
        .empty (empty),
        .dout  (res_dout)
    );

    // result packing: {degenerate, z, y, x}
    assign normal_x   = res_dout[OW-1:0];
    assign normal_y   = res_dout[2*OW-1:OW];
    assign normal_z   = res_dout[3*OW-1:2*OW];
    assign degenerate = res_dout[OUT_W-1];

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("degenerate result with nonzero normal");
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !degenerate) |-> (normal_x <= NMAX && normal_x >= NMIN &&
                                     normal_y <= NMAX && normal_y >= NMIN &&
                                     normal_z <= NMAX && normal_z >= NMIN))
        else $error("normal component out of unit range");
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !degenerate) |-> !(normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("zero normal without degenerate flag");
`endif

endmodule
